[hdl/u8v_pkg.sv]
`timescale 1ns / 1ps
package u8v_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic done_res;
    logic valid_res;
  } out_item_t;

  // Constraint on the byte right after a lead byte
  typedef enum logic [2:0] {
    RULE_NONE   = 3'd0,
    RULE_MIN_A0 = 3'd1,
    RULE_MAX_9F = 3'd2,
    RULE_MIN_90 = 3'd3,
    RULE_MAX_8F = 3'd4
  } rule_t;

  localparam logic [7:0] LEAD_MIN_2B   = 8'hC2;
  localparam logic [7:0] LEAD_E0       = 8'hE0;
  localparam logic [7:0] LEAD_ED       = 8'hED;
  localparam logic [7:0] LEAD_F0       = 8'hF0;
  localparam logic [7:0] LEAD_F4       = 8'hF4;
  localparam logic [7:0] LEAD_OUT_OF_R = 8'hF5;
  localparam logic [7:0] CONT_A0       = 8'hA0;
  localparam logic [7:0] CONT_90       = 8'h90;

  // Classified byte passed from the front end to the back end
  typedef struct packed {
    logic       last;
    logic       is_cont;     // 10xxxxxx
    logic       ge_a0;
    logic       le_9f;
    logic       ge_90;
    logic       le_8f;
    logic       lead_err;    // byte is not a legal lead
    logic [1:0] lead_pending;
    rule_t      lead_rule;
  } cls_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

[hdl/utf8_stream_validator_core.sv]
`timescale 1ns / 1ps
// UTF-8 stream validator.
// Input channel (in_valid/in_ready/in_data): one string byte per transaction,
// with last_byte set on the final byte of the string.
// Output channel (out_valid/out_ready/out_data): one result per input byte.
// done_res echoes last_byte; valid_res is 1 while no error has been seen,
// and on the final byte it is 1 only if the whole string is well formed.
// Throughput: one byte per cycle, sustained while the receiver does not stall,
// set by the combinational classify step in the front end and the state
// update in the back end.
// An accepted byte is written into the two-entry queue and is then popped into
// the output register, where its result appears.
// Reset (rst_n low, synchronous): queue emptied, sequence state cleared,
// output register empty.
// Receiver stall: the output register holds its result; the back end stops
// draining the queue, and in_ready falls once the queue is full, so no
// transaction is lost or repeated.
module utf8_stream_validator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  u8v_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output u8v_pkg::out_item_t out_data
);
  import u8v_pkg::*;

  // Front-to-back queue wiring
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_not_empty;
  cls_t q_push_data;
  cls_t q_pop_data;

  // Classify each byte as it arrives; accept whenever the queue has room
  u8v_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // Short queue decouples a stalled receiver from the sender
  u8v_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  // Track pending continuation bytes, second-byte rule and the sticky error,
  // then register the result for the output channel
  u8v_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

[hdl/u8v_front.sv]
`timescale 1ns / 1ps
module u8v_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  u8v_pkg::in_item_t  in_data,
  input  logic               q_full,
  output logic               q_push,
  output u8v_pkg::cls_t      q_push_data
);
  import u8v_pkg::*;

  logic [7:0] b;

  assign b        = in_data.data_byte;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_push_data              = '0;
    q_push_data.last         = in_data.last_byte;
    q_push_data.is_cont      = (b[7:6] == 2'b10);
    q_push_data.ge_a0        = (b >= CONT_A0);
    q_push_data.le_9f        = (b < CONT_A0);
    q_push_data.ge_90        = (b >= CONT_90);
    q_push_data.le_8f        = (b < CONT_90);
    q_push_data.lead_err     = 1'b0;
    q_push_data.lead_pending = 2'd0;
    q_push_data.lead_rule    = RULE_NONE;
    if (b == 8'h00) begin
      q_push_data.lead_err = 1'b1;
    end else if (b[7] == 1'b0) begin
      q_push_data.lead_pending = 2'd0;
    end else if (b[7:5] == 3'b110) begin
      if (b < LEAD_MIN_2B) q_push_data.lead_err = 1'b1;
      else q_push_data.lead_pending = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      q_push_data.lead_pending = 2'd2;
      if (b == LEAD_E0) q_push_data.lead_rule = RULE_MIN_A0;
      else if (b == LEAD_ED) q_push_data.lead_rule = RULE_MAX_9F;
    end else if (b[7:3] == 5'b11110) begin
      if (b >= LEAD_OUT_OF_R) begin
        q_push_data.lead_err = 1'b1;
      end else begin
        q_push_data.lead_pending = 2'd3;
        if (b == LEAD_F0) q_push_data.lead_rule = RULE_MIN_90;
        else if (b == LEAD_F4) q_push_data.lead_rule = RULE_MAX_8F;
      end
    end else begin
      q_push_data.lead_err = 1'b1;
    end
  end

endmodule

[hdl/u8v_queue.sv]
`timescale 1ns / 1ps
module u8v_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u8v_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output u8v_pkg::cls_t pop_data,
  output logic          not_empty
);
  import u8v_pkg::*;

  cls_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r;
  logic [QUEUE_AW-1:0]  rd_ptr_r;
  logic [QUEUE_AW:0]    count_r;
  logic [QUEUE_AW:0]    count_nxt;

  assign full      = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

[hdl/u8v_back.sv]
`timescale 1ns / 1ps
module u8v_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  u8v_pkg::cls_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output u8v_pkg::out_item_t out_data
);
  import u8v_pkg::*;

  logic [1:0] pending_r, pending_nxt;
  rule_t      rule_r, rule_nxt;
  logic       err_r, err_nxt;
  logic       out_valid_r;
  out_item_t  out_r;
  logic       rule_ok;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (rule_r)
      RULE_MIN_A0: rule_ok = q_data.ge_a0;
      RULE_MAX_9F: rule_ok = q_data.le_9f;
      RULE_MIN_90: rule_ok = q_data.ge_90;
      RULE_MAX_8F: rule_ok = q_data.le_8f;
      default:     rule_ok = 1'b1;
    endcase
  end

  always_comb begin
    pending_nxt = pending_r;
    rule_nxt    = rule_r;
    err_nxt     = err_r;
    if (!err_r) begin
      if (pending_r != 2'd0) begin
        if (!q_data.is_cont || !rule_ok) begin
          err_nxt = 1'b1;
        end else begin
          pending_nxt = pending_r - 2'd1;
          rule_nxt    = RULE_NONE;
        end
      end else begin
        rule_nxt = q_data.lead_rule;
        if (q_data.lead_err) err_nxt = 1'b1;
        else pending_nxt = q_data.lead_pending;
      end
      // truncated sequence at end of string
      if (q_data.last && pending_nxt != 2'd0) err_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 2'd0;
      rule_r      <= RULE_NONE;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
        if (q_data.last) begin
          pending_r <= 2'd0;
          rule_r    <= RULE_NONE;
          err_r     <= 1'b0;
        end else begin
          pending_r <= pending_nxt;
          rule_r    <= rule_nxt;
          err_r     <= err_nxt;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r.done_res  <= q_data.last;
      out_r.valid_res <= !err_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.last) |=> (pending_r == 2'd0 && !err_r && rule_r == RULE_NONE))
    else $error("state not cleared after final byte");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && !(q_pop && q_data.last)) |=> err_r)
    else $error("error flag dropped inside a string");

  a_err_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && err_r) |=> (out_valid_r && !out_r.valid_res))
    else $error("result marked valid after an error");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import u8v_pkg::*;

  // Run length guard, in clock cycles: far above the slowest correct run
  localparam int CYCLE_LIMIT = 200000;
  // Random bytes to plan for each idling phase
  localparam int PHASE_BYTES = 550;
  // Cycles to keep watching the result channel once everything is drained
  localparam int TAIL_CYCLES = 8;

  // Directed strings, one byte per entry: bit 8 is the last-byte flag
  localparam int DIR_COUNT = 27;
  localparam logic [8:0] DIRECTED [DIR_COUNT] = '{
    9'h100,                          // zero byte at lead position
    9'h180,                          // continuation byte at lead position
    9'h0C1, 9'h1BF,                  // overlong two-byte lead
    9'h0C2, 9'h080, 9'h17F,          // smallest two-byte form, then ASCII top
    9'h0E0, 9'h09F, 9'h180,          // overlong three-byte form, then ignored byte
    9'h0ED, 9'h0A0, 9'h180,          // surrogate
    9'h0F0, 9'h18F,                  // overlong four-byte form
    9'h0F4, 9'h190,                  // above the code point ceiling
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,  // highest legal code point
    9'h1F5,                          // out-of-range lead
    9'h1FF,                          // lead from F8 up
    9'h0E1, 9'h180,                  // sequence cut short by the last byte
    9'h0C2, 9'h141                   // ASCII where a continuation is due
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Bytes waiting to be offered, and verdicts waiting to be returned
  in_item_t  byte_plan[$];
  out_item_t verdict_q[$];

  // Idle odds in percent, changed by the sequencer between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  int planned_bytes = 0;

  // Shadow copy of the checker's sequence state
  logic [1:0] pend_cnt;
  rule_t      next_rule;
  logic       seq_err;

  utf8_stream_validator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the shadow state by one accepted byte and queue the verdict it yields
  task automatic predict_verdict(input in_item_t item);
    logic [7:0] b;
    out_item_t  res;
    b = item.data_byte;
    if (!seq_err) begin
      if (pend_cnt != 2'd0) begin
        // A continuation is due: check its form and any rule left by the lead
        if (b[7:6] != 2'b10) begin
          seq_err = 1'b1;
        end else begin
          case (next_rule)
            RULE_MIN_A0: seq_err = (b < CONT_A0);
            RULE_MAX_9F: seq_err = (b >= CONT_A0);
            RULE_MIN_90: seq_err = (b < CONT_90);
            RULE_MAX_8F: seq_err = (b >= CONT_90);
            default:     seq_err = 1'b0;
          endcase
          if (!seq_err) begin
            pend_cnt  = pend_cnt - 2'd1;
            next_rule = RULE_NONE;
          end
        end
      end else begin
        // Lead position: classify the byte by its top bits
        next_rule = RULE_NONE;
        if (b == 8'h00) begin
          seq_err = 1'b1;
        end else if (!b[7]) begin
          pend_cnt = 2'd0;
        end else if (b[7:5] == 3'b110) begin
          if (b < LEAD_MIN_2B) seq_err = 1'b1;
          else pend_cnt = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          pend_cnt = 2'd2;
          if (b == LEAD_E0) next_rule = RULE_MIN_A0;
          else if (b == LEAD_ED) next_rule = RULE_MAX_9F;
        end else if (b[7:3] == 5'b11110) begin
          if (b >= LEAD_OUT_OF_R) begin
            seq_err = 1'b1;
          end else begin
            pend_cnt = 2'd3;
            if (b == LEAD_F0) next_rule = RULE_MIN_90;
            else if (b == LEAD_F4) next_rule = RULE_MAX_8F;
          end
        end else begin
          seq_err = 1'b1;
        end
      end
      // The last byte may not leave a sequence open
      if (item.last_byte && pend_cnt != 2'd0) seq_err = 1'b1;
    end
    res.done_res  = item.last_byte;
    res.valid_res = !seq_err;
    verdict_q.push_back(res);
    if (item.last_byte) begin
      pend_cnt  = 2'd0;
      next_rule = RULE_NONE;
      seq_err   = 1'b0;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    in_item_t item;
    item.data_byte = b;
    item.last_byte = fin;
    byte_plan.push_back(item);
    planned_bytes++;
  endtask

  // Pick a byte in [lo, hi], leaning on the two bounds
  function automatic logic [7:0] pick_byte(input logic [7:0] lo, input logic [7:0] hi);
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      default: return 8'($urandom_range(32'(hi), 32'(lo)));
    endcase
  endfunction

  // Build one string: mostly well-formed characters, some damaged, some pure noise
  task automatic queue_random_string();
    logic [7:0] seq[$];
    logic [7:0] lead;
    int         pos;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(6, 1)) seq.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(10, 1)) begin
        case ($urandom_range(3))
          0: seq.push_back(pick_byte(8'h01, 8'h7F));
          1: begin
            seq.push_back(pick_byte(LEAD_MIN_2B, 8'hDF));
            seq.push_back(pick_byte(8'h80, 8'hBF));
          end
          2: begin
            case ($urandom_range(3))
              0:       lead = LEAD_E0;
              1:       lead = LEAD_ED;
              default: lead = pick_byte(8'hE1, 8'hEF);
            endcase
            seq.push_back(lead);
            if (lead == LEAD_E0) seq.push_back(pick_byte(CONT_A0, 8'hBF));
            else if (lead == LEAD_ED) seq.push_back(pick_byte(8'h80, 8'h9F));
            else seq.push_back(pick_byte(8'h80, 8'hBF));
            seq.push_back(pick_byte(8'h80, 8'hBF));
          end
          default: begin
            case ($urandom_range(3))
              0:       lead = LEAD_F0;
              1:       lead = LEAD_F4;
              default: lead = pick_byte(8'hF1, 8'hF3);
            endcase
            seq.push_back(lead);
            if (lead == LEAD_F0) seq.push_back(pick_byte(CONT_90, 8'hBF));
            else if (lead == LEAD_F4) seq.push_back(pick_byte(8'h80, 8'h8F));
            else seq.push_back(pick_byte(8'h80, 8'hBF));
            seq.push_back(pick_byte(8'h80, 8'hBF));
            seq.push_back(pick_byte(8'h80, 8'hBF));
          end
        endcase
      end
      // Damage some strings: overwrite a byte, cut the tail, or slip in a stray continuation
      if ($urandom_range(99) < 25) begin
        pos = $urandom_range(seq.size() - 1);
        case ($urandom_range(2))
          0: seq[pos] = 8'($urandom);
          1: if (seq.size() > 1) void'(seq.pop_back());
          default: seq.insert(pos, pick_byte(8'h80, 8'hBF));
        endcase
      end
    end
    foreach (seq[i]) queue_byte(seq[i], i == seq.size() - 1);
  endtask

  // Driver: predict on each accepted transaction, then offer the next byte or idle.
  // Valid is only lowered or reloaded once the current transaction is gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      pend_cnt  = 2'd0;
      next_rule = RULE_NONE;
      seq_err   = 1'b0;
    end else begin
      if (in_valid && in_ready) predict_verdict(in_data);
      if (!in_valid || in_ready) begin
        if (byte_plan.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= byte_plan.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest verdict, stall at random
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result: done_res=%0b valid_res=%0b",
                 out_data.done_res, out_data.valid_res);
          error_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data.done_res !== want.done_res) begin
            $error("done_res mismatch: expected %0b, actual %0b",
                   want.done_res, out_data.done_res);
            error_count++;
          end
          if (out_data.valid_res !== want.valid_res) begin
            $error("valid_res mismatch: expected %0b, actual %0b",
                   want.valid_res, out_data.valid_res);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Guard: drop the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Hold the sequencer until every offered byte is accepted and every verdict is back
  task automatic wait_drained();
    while (byte_plan.size() > 0 || in_valid || verdict_q.size() > 0) @(negedge clk);
  endtask

  // Sequencer: reset, directed strings, then three random phases with different idling
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 88;
    for (int i = 0; i < DIR_COUNT; i++) queue_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drained();

    // Sender rarely idles, receiver mostly stalls
    planned_bytes = 0;
    while (planned_bytes < PHASE_BYTES) queue_random_string();
    wait_drained();

    // Swap the roles: sender mostly idles, receiver rarely stalls
    send_idle_pct = 88;
    recv_idle_pct = 7;
    planned_bytes = 0;
    while (planned_bytes < PHASE_BYTES) queue_random_string();
    wait_drained();

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    planned_bytes = 0;
    while (planned_bytes < PHASE_BYTES) queue_random_string();
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && verdict_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
